[rtl/core/hsfd_pkg.sv]
`default_nettype none

package hsfd_pkg;

  // CRC-8 as used by the sensor: polynomial 0x31, seed 0xFF, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion constants, scaled so that all arithmetic stays integral.
  localparam int unsigned FULL_SCALE    = 65535;
  localparam int unsigned TEMP_GAIN     = 1750;    // 175 degC in tenths
  localparam int unsigned TEMP_BASE     = 450;     // 45 degC in tenths
  localparam int unsigned HUM_GAIN      = 125;
  localparam int unsigned HUM_BASE      = 262140;  // 4 percent times full scale
  localparam int unsigned HUM_MAX       = 100;
  localparam int unsigned TEMP_MAX      = 127;
  localparam int unsigned TEMP_MIN_MAG  = 128;

  // Widths of the temperature datapath.
  localparam int unsigned MAG_W   = 27;
  localparam int unsigned NUM_W   = MAG_W + 1;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned HX_W    = 24;

  // Division by ten times full scale (655350) is a multiplication by 2^47 / 655350,
  // rounded up, followed by a right shift of 47. The rounding error times any
  // magnitude below 2^27 stays under 2^47, so the quotient is exact.
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned RECIP_SHIFT = 47;
  localparam logic [RECIP_W-1:0] TEMP_RECIP = 28'd214751642;

  // Reset values of the configuration registers.
  localparam logic [7:0] OFFSET_ON_RESET  = 8'd22;
  localparam logic [7:0] OFFSET_OFF_RESET = 8'd12;

  // Default depth of the frame queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DISPLAY_ON  = 2'd0;
  localparam logic [1:0] CFG_OFFSET_ON   = 2'd1;
  localparam logic [1:0] CFG_OFFSET_OFF  = 2'd2;

  // Position of the next byte within a frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // One checked frame, handed from the front end to the back end.
  typedef struct packed {
    logic        crc_bad;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_t;

  // Folds one byte into a running CRC.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/humidity_sensor_frame_decode_unit.sv]
// Path: a frame waits in the frame queue until the back end is idle, then passes the
// back end states MUL, PREP, DIV and OUT. Throughput: one byte per cycle, except that
// a closing byte stalls on a full frame queue, so only while results are not popped.
// Reset: rst_ni is asynchronous and active low; it empties the queues, restarts the
// frame at its first byte and loads the configuration registers with 0, 22 and 12.
`default_nettype none

module humidity_sensor_frame_decode_unit #(
  parameter int unsigned QueueDepth = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             crc_error_o,
  output logic signed [7:0] temperature_o,
  output logic [6:0]       humidity_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic             display_on_q;
  logic [7:0]       offset_on_q, offset_off_q;
  logic [7:0]       offset;

  logic             fq_push, fq_full, fq_pop, fq_empty;
  hsfd_pkg::frame_t fq_wdata, fq_rdata;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_on_q <= 1'b0;
      offset_on_q  <= hsfd_pkg::OFFSET_ON_RESET;
      offset_off_q <= hsfd_pkg::OFFSET_OFF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hsfd_pkg::CFG_DISPLAY_ON: display_on_q <= cfg_data_i[0];
        hsfd_pkg::CFG_OFFSET_ON:  offset_on_q  <= cfg_data_i;
        hsfd_pkg::CFG_OFFSET_OFF: offset_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign offset = display_on_q ? offset_on_q : offset_off_q;

  hsfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .rx_byte_i (rx_byte_i),
    .fq_push_o (fq_push),
    .fq_full_i (fq_full),
    .fq_data_o (fq_wdata)
  );

  hsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_rdata),
    .empty_o (fq_empty)
  );

  hsfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fq_empty_i    (fq_empty),
    .fq_data_i     (fq_rdata),
    .fq_pop_o      (fq_pop),
    .offset_i      (offset),
    .empty         (empty),
    .pop           (pop),
    .crc_error_o   (crc_error_o),
    .temperature_o (temperature_o),
    .humidity_o    (humidity_o)
  );

`ifndef SYNTH
  // The front end never pushes a frame into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fq_push && fq_full))
    else $error("frame queue overflow");

  // The back end never takes a frame from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fq_pop && fq_empty))
    else $error("frame queue underflow");

  // A CRC error carries zero readings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && crc_error_o) |-> (temperature_o == 8'sd0 && humidity_o == 7'd0))
    else $error("readings not cleared on CRC error");

  // Humidity stays within its clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (humidity_o <= 7'(hsfd_pkg::HUM_MAX)))
    else $error("humidity out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/hsfd_front.sv]
`default_nettype none

module hsfd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 fq_push_o,
  input  wire logic            fq_full_i,
  output hsfd_pkg::frame_t     fq_data_o
);

  hsfd_pkg::pos_e pos_q, pos_d;
  logic [7:0]     crc_q, crc_d;
  logic [15:0]    temp_word_q, temp_word_d;
  logic [7:0]     hum_hi_q, hum_hi_d;
  logic [7:0]     hum_lo_q;
  logic           temp_bad_q, temp_bad_d;
  logic           accept;

  // Only the closing byte of a frame needs room in the queue.
  assign full   = (pos_q == hsfd_pkg::POS_H_CRC) && fq_full_i;
  assign accept = push && !full;

  // Frame assembly and CRC tracking.
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    hum_hi_d    = hum_hi_q;
    temp_bad_d  = temp_bad_q;
    fq_push_o   = 1'b0;
    fq_data_o.crc_bad  = temp_bad_q || (crc_q != rx_byte_i);
    fq_data_o.temp_raw = temp_word_q;
    fq_data_o.hum_raw  = {hum_hi_q, hum_lo_q};
    if (accept) begin
      unique case (pos_q)
        hsfd_pkg::POS_T_LO: begin
          temp_word_d = {temp_word_q[15:8], rx_byte_i};
          crc_d       = hsfd_pkg::crc8_feed(crc_q, rx_byte_i);
          pos_d       = hsfd_pkg::POS_T_CRC;
        end
        hsfd_pkg::POS_T_CRC: begin
          temp_bad_d = (crc_q != rx_byte_i);
          crc_d      = hsfd_pkg::CRC_INIT;
          pos_d      = hsfd_pkg::POS_H_HI;
        end
        hsfd_pkg::POS_H_HI: begin
          hum_hi_d = rx_byte_i;
          crc_d    = hsfd_pkg::crc8_feed(crc_q, rx_byte_i);
          pos_d    = hsfd_pkg::POS_H_LO;
        end
        hsfd_pkg::POS_H_LO: begin
          // The low byte itself is captured in its own register below.
          crc_d    = hsfd_pkg::crc8_feed(crc_q, rx_byte_i);
          pos_d    = hsfd_pkg::POS_H_CRC;
        end
        hsfd_pkg::POS_H_CRC: begin
          fq_push_o = 1'b1;
          crc_d     = hsfd_pkg::CRC_INIT;
          pos_d     = hsfd_pkg::POS_T_HI;
        end
        default: begin
          // First byte of a frame.
          crc_d       = hsfd_pkg::crc8_feed(hsfd_pkg::CRC_INIT, rx_byte_i);
          temp_word_d = {rx_byte_i, 8'h00};
          pos_d       = hsfd_pkg::POS_T_LO;
        end
      endcase
    end
  end

  // The humidity low byte must survive until the CRC byte arrives.
  always_ff @(posedge clk_i) begin
    if (accept && (pos_q == hsfd_pkg::POS_H_LO)) begin
      hum_lo_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= hsfd_pkg::POS_T_HI;
      crc_q       <= hsfd_pkg::CRC_INIT;
      temp_word_q <= '0;
      hum_hi_q    <= '0;
      temp_bad_q  <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      hum_hi_q    <= hum_hi_d;
      temp_bad_q  <= temp_bad_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hsfd_queue.sv]
`default_nettype none

module hsfd_queue #(
  parameter int unsigned Depth = hsfd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hsfd_pkg::frame_t  data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output hsfd_pkg::frame_t       data_o,
  output logic                   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsfd_pkg::frame_t slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Frame storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers wrap at the last slot, so any depth works.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/hsfd_back.sv]
`default_nettype none

module hsfd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fq_empty_i,
  input  wire hsfd_pkg::frame_t  fq_data_i,
  output logic                   fq_pop_o,
  input  wire logic [7:0]        offset_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   crc_error_o,
  output logic signed [7:0]      temperature_o,
  output logic [6:0]             humidity_o
);

  localparam int unsigned MagW   = hsfd_pkg::MAG_W;
  localparam int unsigned NumW   = hsfd_pkg::NUM_W;
  localparam int unsigned QuotW  = hsfd_pkg::QUOT_W;
  localparam int unsigned HxW    = hsfd_pkg::HX_W;
  localparam int unsigned RecipW = hsfd_pkg::RECIP_W;
  localparam int unsigned ProdW  = MagW + RecipW;
  localparam int unsigned Shift  = hsfd_pkg::RECIP_SHIFT;

  hsfd_pkg::back_state_e state_q, state_d;

  // Datapath registers.
  logic              bad_q;
  logic [15:0]       temp_raw_q, hum_raw_q;
  logic [NumW-1:0]   num_q;
  logic [HxW-1:0]    hx_q;
  logic              neg_q;
  logic [MagW-1:0]   mag_q;
  logic [ProdW-1:0]  prod_q;
  logic [6:0]        hum_q;
  logic              out_valid_q;

  // Products of the first step.
  logic [9:0]        off_sum;
  logic [MagW-1:0]   pos_term, neg_term;
  logic [NumW-1:0]   num_d;
  logic [HxW-1:0]    hx_d;

  // Humidity reduction by 65535: quotient from the top bits, one correction.
  logic [7:0]        hq0;
  logic [16:0]       hrem;
  logic [7:0]        hq;

  // Temperature magnitude divided by 655350 through its reciprocal.
  logic [ProdW-1:0]  prod_d;
  logic [QuotW-1:0]  quot;

  // Saturated temperature.
  logic [8:0]        quot_ext;
  logic signed [7:0] temp_sat;

  logic              out_load;

  assign off_sum  = 10'(hsfd_pkg::TEMP_BASE) + 10'(offset_i);
  assign pos_term = MagW'(temp_raw_q) * MagW'(hsfd_pkg::TEMP_GAIN);
  assign neg_term = MagW'(off_sum) * MagW'(hsfd_pkg::FULL_SCALE);
  assign num_d    = {1'b0, pos_term} - {1'b0, neg_term};
  assign hx_d     = HxW'(hum_raw_q) * HxW'(hsfd_pkg::HUM_GAIN) + HxW'(hsfd_pkg::HUM_BASE);

  assign hq0  = hx_q[HxW-1:16];
  assign hrem = {1'b0, hx_q[15:0]} + 17'(hq0);
  assign hq   = hq0 + 8'(hrem >= 17'(hsfd_pkg::FULL_SCALE));

  assign prod_d = ProdW'(mag_q) * ProdW'(hsfd_pkg::TEMP_RECIP);
  assign quot   = prod_q[Shift +: QuotW];

  assign quot_ext = {1'b0, quot};
  always_comb begin
    if (neg_q) begin
      temp_sat = (quot_ext > 9'(hsfd_pkg::TEMP_MIN_MAG)) ? 8'sh80 : 8'(-quot_ext);
    end else begin
      temp_sat = (quot_ext > 9'(hsfd_pkg::TEMP_MAX)) ? 8'sd127 : 8'(quot_ext);
    end
  end

  assign empty = !out_valid_q;

  // Sequencer: take a frame, multiply, prepare, divide, hand over.
  always_comb begin
    state_d  = state_q;
    fq_pop_o = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      hsfd_pkg::BK_IDLE: begin
        if (!fq_empty_i) begin
          fq_pop_o = 1'b1;
          state_d  = hsfd_pkg::BK_MUL;
        end
      end
      hsfd_pkg::BK_MUL: begin
        state_d = hsfd_pkg::BK_PREP;
      end
      hsfd_pkg::BK_PREP: begin
        state_d = hsfd_pkg::BK_DIV;
      end
      hsfd_pkg::BK_DIV: begin
        state_d = hsfd_pkg::BK_OUT;
      end
      hsfd_pkg::BK_OUT: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = hsfd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = hsfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsfd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic registers advance with the sequencer.
  always_ff @(posedge clk_i) begin
    if (fq_pop_o) begin
      bad_q      <= fq_data_i.crc_bad;
      temp_raw_q <= fq_data_i.temp_raw;
      hum_raw_q  <= fq_data_i.hum_raw;
    end
    if (state_q == hsfd_pkg::BK_MUL) begin
      num_q <= num_d;
      hx_q  <= hx_d;
    end
    if (state_q == hsfd_pkg::BK_PREP) begin
      neg_q <= num_q[NumW-1];
      mag_q <= num_q[NumW-1] ? MagW'(-num_q) : num_q[MagW-1:0];
      hum_q <= (hq > 8'(hsfd_pkg::HUM_MAX)) ? 7'(hsfd_pkg::HUM_MAX) : hq[6:0];
    end
    if (state_q == hsfd_pkg::BK_DIV) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      crc_error_o   <= bad_q;
      temperature_o <= bad_q ? 8'sd0 : temp_sat;
      humidity_o    <= bad_q ? 7'd0 : hum_q;
    end
  end

endmodule

`default_nettype wire
